### sv/mavg_pkg.sv
// Shared constants and types for the moving average window block.
package mavg_pkg;

  // Width of the window length register and its value after reset.
  localparam int LEN_W = 7;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd5;

  typedef logic [LEN_W-1:0] win_len_t;

  // Item operations.
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_FILL = 1'b1
  } opcode_t;

endpackage

### sv/mavg_if.sv
// Valid/ready channel interfaces for the moving average window block.
interface mavg_in_if #(
  parameter int SAMPLE_BITS = 16
);
  import mavg_pkg::*;

  logic                          valid;
  logic                          ready;
  opcode_t                       opcode;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface mavg_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

interface mavg_cfg_if;
  import mavg_pkg::*;

  logic     valid;
  logic     ready;
  win_len_t window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

### sv/moving_average_window.sv
// Boxcar moving average over a configurable window, with a shared adder and a sequencer.
//
//   channel   direction  payload                 transfer when
//   in_chan   sink       opcode, sample          valid && ready
//   out_chan  source     average                 valid && ready
//   cfg_chan  sink       window_length           valid && ready
//
// An add item, once taken, runs the subtract, add, magnitude, division and
// sign steps in turn; the sign step loads its result into the output register.
// A fill item first runs the sweep that writes every store entry, then the
// magnitude, division and sign steps. The shared adder is the unit that
// bounds all of this: the quotient is produced one bit per cycle.
// After reset a clearing pass over every store entry zeroes the store; no
// item is taken meanwhile, though length writes are. A length write then
// keeps the block busy while the sum is rebuilt from the store.
// A stalled result sits in the output register; the next item may be taken
// while it waits, and that item only holds at its last step if it is still
// waiting then.
module moving_average_window #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mavg_in_if.sink     in_chan,
  mavg_out_if.source  out_chan,
  mavg_cfg_if.sink    cfg_chan
);
  import mavg_pkg::*;

  // Store index, count, effective length and running sum widths.
  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int EL_W   = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  localparam int SUM_W  = SAMPLE_BITS + IDX_W;
  localparam int STEP_W = $clog2(SAMPLE_BITS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;  // sweep writing every entry (also reset clear)
  localparam logic [2:0] S_SUM  = 3'd2;  // rebuild the sum after a length write
  localparam logic [2:0] S_SUB  = 3'd3;  // take the overwritten entry off the sum
  localparam logic [2:0] S_ADD  = 3'd4;  // add the new sample and store it
  localparam logic [2:0] S_ABS  = 3'd5;  // magnitude of the sum
  localparam logic [2:0] S_DIV  = 3'd6;  // one quotient bit per cycle
  localparam logic [2:0] S_SIGN = 3'd7;  // restore the sign and load the result

  logic [2:0]                    state_r, state_nxt;
  logic [IDX_W-1:0]              pos_r, pos_nxt;
  logic [SUM_W-1:0]              sum_r, sum_nxt;
  logic [EL_W-1:0]               idx_r, idx_nxt;
  logic signed [SAMPLE_BITS-1:0] val_r, val_nxt;
  win_len_t                      len_r, len_nxt;
  logic                          fill_item_r, fill_item_nxt;
  logic                          pend_r, pend_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic [SUM_W-1:0]              rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0]        quo_r, quo_nxt;
  logic                          neg_r, neg_nxt;

  // Window store: one write and one registered read per cycle.
  logic signed [SAMPLE_BITS-1:0] window_mem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  logic [IDX_W-1:0]              mem_raddr;

  // Shared adder/subtractor; the top bit is the carry, set when a >= b on a subtract.
  logic [SUM_W-1:0]              alu_a, alu_b;
  logic                          alu_sub;
  logic [SUM_W:0]                alu_res;

  logic [EL_W-1:0]               len_ext, eff_len, pos_inc;
  logic [IDX_W-1:0]              pos_eff;
  logic [SUM_W-1:0]              divisor, val_ext, rd_ext, quo_ext, div_shift;
  logic                          in_acc, cfg_acc;

  // A zero length counts as one; lengths beyond the store saturate.
  always_comb begin
    len_ext = EL_W'(len_r);
    if (len_r == '0) begin
      eff_len = EL_W'(1);
    end else if (len_ext > EL_W'(MAX_WINDOW)) begin
      eff_len = EL_W'(MAX_WINDOW);
    end else begin
      eff_len = len_ext;
    end
  end

  assign pos_eff   = (EL_W'(pos_r) >= eff_len) ? '0 : pos_r;
  assign pos_inc   = EL_W'(pos_eff) + EL_W'(1);
  assign divisor   = {{(SUM_W - EL_W){1'b0}}, eff_len};
  assign val_ext   = {{IDX_W{val_r[SAMPLE_BITS-1]}}, val_r};
  assign rd_ext    = {{IDX_W{rd_data_r[SAMPLE_BITS-1]}}, rd_data_r};
  assign quo_ext   = {{IDX_W{1'b0}}, quo_r};
  assign div_shift = {rem_r[SUM_W-2:0], quo_r[SAMPLE_BITS-1]};

  assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (SUM_W + 1)'(alu_sub);

  // Length writes are taken when idle and during the reset clear; an item only
  // when idle and no length write is offered in the same cycle.
  assign cfg_chan.ready = (state_r == S_IDLE) || ((state_r == S_FILL) && !fill_item_r);
  assign in_chan.ready  = (state_r == S_IDLE) && !cfg_chan.valid;
  assign cfg_acc        = cfg_chan.valid && cfg_chan.ready;
  assign in_acc         = in_chan.valid && in_chan.ready;

  assign out_chan.valid   = out_valid_r;
  assign out_chan.average = avg_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    len_nxt       = len_r;
    fill_item_nxt = fill_item_r;
    pend_nxt      = 1'b0;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    avg_nxt       = avg_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_eff;
    mem_raddr     = pos_eff;
    alu_a         = sum_r;
    alu_b         = '0;
    alu_sub       = 1'b0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // The store entry at the write position is read on every idle cycle,
        // so it is ready for an add item in the cycle after its transfer.
        if (cfg_acc) begin
          len_nxt   = cfg_chan.window_length;
          pos_nxt   = '0;
          idx_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = S_SUM;
        end else if (in_acc) begin
          val_nxt = in_chan.sample;
          if (in_chan.opcode == OP_FILL) begin
            fill_item_nxt = 1'b1;
            idx_nxt       = '0;
            sum_nxt       = '0;
            state_nxt     = S_FILL;
          end else begin
            state_nxt = S_SUB;
          end
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[IDX_W-1:0];
        alu_b     = val_ext;
        if (idx_r < eff_len) begin
          sum_nxt = alu_res[SUM_W-1:0];
        end
        idx_nxt = idx_r + EL_W'(1);
        if (idx_r == EL_W'(MAX_WINDOW - 1)) begin
          state_nxt = fill_item_r ? S_ABS : S_IDLE;
        end
        // During the reset clear every entry is zero, so the sum stays zero
        // whatever length is written here.
        if (cfg_acc) begin
          len_nxt = cfg_chan.window_length;
          pos_nxt = '0;
        end
      end
      S_SUM: begin
        mem_raddr = idx_r[IDX_W-1:0];
        if (idx_r < eff_len) begin
          idx_nxt  = idx_r + EL_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          alu_b   = rd_ext;
          sum_nxt = alu_res[SUM_W-1:0];
        end
        if ((idx_r == eff_len) && !pend_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_SUB: begin
        alu_b     = rd_ext;
        alu_sub   = 1'b1;
        sum_nxt   = alu_res[SUM_W-1:0];
        state_nxt = S_ADD;
      end
      S_ADD: begin
        alu_b     = val_ext;
        sum_nxt   = alu_res[SUM_W-1:0];
        mem_we    = 1'b1;
        pos_nxt   = (pos_inc >= eff_len) ? '0 : pos_inc[IDX_W-1:0];
        state_nxt = S_ABS;
      end
      S_ABS: begin
        neg_nxt = sum_r[SUM_W-1];
        if (sum_r[SUM_W-1]) begin
          alu_a   = '0;
          alu_b   = sum_r;
          alu_sub = 1'b1;
        end
        // The quotient fits in SAMPLE_BITS, so the bits above them are
        // already below the divisor and seed the partial remainder.
        rem_nxt   = alu_res[SUM_W-1:0] >> SAMPLE_BITS;
        quo_nxt   = alu_res[SAMPLE_BITS-1:0];
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        alu_a   = div_shift;
        alu_b   = divisor;
        alu_sub = 1'b1;
        rem_nxt = alu_res[SUM_W] ? alu_res[SUM_W-1:0] : div_shift;
        quo_nxt = {quo_r[SAMPLE_BITS-2:0], alu_res[SUM_W]};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SAMPLE_BITS - 1)) begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        alu_a   = neg_r ? '0 : quo_ext;
        alu_b   = neg_r ? quo_ext : '0;
        alu_sub = neg_r;
        if (!out_valid_r || out_chan.ready) begin
          avg_nxt       = alu_res[SAMPLE_BITS-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      pos_r       <= '0;
      sum_r       <= '0;
      idx_r       <= '0;
      val_r       <= '0;
      len_r       <= LEN_RESET;
      fill_item_r <= 1'b0;
      pend_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      val_r       <= val_nxt;
      len_r       <= len_nxt;
      fill_item_r <= fill_item_nxt;
      pend_r      <= pend_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avg_r <= avg_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      window_mem[mem_waddr] <= val_r;
    end
    rd_data_r <= window_mem[mem_raddr];
  end

  // The write position always lies inside the active window between items.
  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (EL_W'(pos_r) < eff_len))
    else $error("write position outside the active window");

  // The partial remainder stays below the divisor throughout the division.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < divisor))
    else $error("divider remainder not below the window length");

  // A result only becomes valid out of the sign step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_SIGN))
    else $error("result raised outside the sign step");

endmodule

### sim/moving_average_window_tb.sv
// Self-checking testbench for the moving average window block.
module moving_average_window_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mavg_pkg::*;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int ITEM_TARGET = 700;
  // Time limit for the whole run; a correct run ends well within it.
  localparam int RUN_LIMIT_NS = 1_000_000;
  // Cycles granted after the last result before the verdict is given.
  localparam int SETTLE_CYCLES = 100;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  logic clk = 1'b0;
  logic rst_n;

  mavg_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_chan ();
  mavg_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_chan ();
  mavg_cfg_if                              cfg_chan ();

  moving_average_window #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  // The clock runs with a period of 2 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Our own picture of the block: the ring of samples, the write position,
  // the exact sum of the active window and the length register as written.
  sample_t  window_copy [MAX_WINDOW];
  int       write_slot;
  longint   window_sum;
  win_len_t length_reg;

  // Averages still owed by the block, oldest first.
  sample_t expected_averages [$];

  int  errors        = 0;
  int  items_sent    = 0;
  int  fills_sent    = 0;
  int  results_seen  = 0;
  int  length_writes = 0;
  int  longest_window  = 0;
  int  shortest_window = MAX_WINDOW;

  // When set, neither side idles between transfers.
  bit  no_gaps = 1'b0;
  // A request to the receiver to hold off; hold_cycles sets how long.
  bit  hold_request = 1'b0;
  int  hold_cycles  = 0;

  // A length of zero behaves as one, and anything past the store is clipped.
  function automatic int effective_length();
    if (length_reg == '0) begin
      return 1;
    end
    if (int'(length_reg) > MAX_WINDOW) begin
      return MAX_WINDOW;
    end
    return int'(length_reg);
  endfunction

  // A length write restarts the ring at slot zero and rebuilds the sum from
  // whatever the store holds; nothing is refilled.
  function automatic void take_length_write(win_len_t value);
    int len;
    length_reg = value;
    write_slot = 0;
    len        = effective_length();
    window_sum = 0;
    for (int i = 0; i < len; i++) begin
      window_sum += longint'(window_copy[i]);
    end
    if (len > longest_window) begin
      longest_window = len;
    end
    if (len < shortest_window) begin
      shortest_window = len;
    end
  endfunction

  // Applies one item to our copy of the state and returns the average that
  // the block must produce for it. The division truncates toward zero.
  function automatic sample_t average_after(opcode_t op, sample_t value);
    int     len;
    int     slot;
    longint quotient;
    len = effective_length();
    if (op == OP_ADD) begin
      slot = write_slot;
      if (slot >= len) begin
        slot = 0;
      end
      window_sum += longint'(value) - longint'(window_copy[slot]);
      window_copy[slot] = value;
      slot++;
      if (slot >= len) begin
        slot = 0;
      end
      write_slot = slot;
    end else begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        window_copy[i] = value;
      end
      window_sum = longint'(value) * longint'(len);
    end
    quotient = window_sum / longint'(len);
    return quotient[SAMPLE_BITS-1:0];
  endfunction

  // Samples lean towards the extremes and small values so that truncation
  // of negative sums and overflow-prone sums both turn up often.
  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return sample_t'(16'sh7fff);
      1: return sample_t'(16'sh8000);
      2: return sample_t'(int'($urandom_range(0, 20)) - 10);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offers one item after a random pause and waits for its transfer. The
  // valid line is left high so that a following item can go straight out.
  task automatic send_item(opcode_t op, sample_t value);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.opcode <= op;
    in_chan.sample <= value;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_averages.push_back(average_after(op, value));
    items_sent++;
    if (op == OP_FILL) begin
      fills_sent++;
    end
  endtask

  // Lowers valid and waits until every owed average has been seen. It always
  // waits on the clock before checking, so valid is never lowered and raised in
  // the same time step.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_averages.size() != 0) @(posedge clk);
  endtask

  // Writes the window length. Only called with nothing in flight.
  task automatic write_length(win_len_t value);
    cfg_chan.valid         <= 1'b1;
    cfg_chan.window_length <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    take_length_write(value);
    length_writes++;
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // With the reset length of five: both extremes, minus one and one, and a
  // window whose sum is minus one, which must round to zero and not to minus
  // one. Then a fill at the negative extreme followed by one add.
  task automatic test_reset_length();
    send_item(OP_ADD, 16'sh7fff);
    send_item(OP_ADD, 16'sh8000);
    send_item(OP_ADD, -16'sd1);
    send_item(OP_ADD, 16'sd1);
    send_item(OP_ADD, 16'sd0);
    send_item(OP_FILL, 16'sh8000);
    send_item(OP_ADD, 16'sh7fff);
    drain();
  endtask

  // Length writes at and beyond the ends of the range. Every write but the
  // one of 127 is left without a fill first, so the rebuilt sum is checked as well.
  task automatic test_length_extremes();
    write_length(win_len_t'(1));
    send_item(OP_ADD, 16'sd1234);
    send_item(OP_FILL, 16'sd7);
    drain();
    // A zero length behaves as a window of one.
    write_length(win_len_t'(0));
    send_item(OP_ADD, -16'sd5);
    send_item(OP_ADD, 16'sd3);
    drain();
    // The largest register value is clipped to the full store.
    write_length(win_len_t'(127));
    send_item(OP_FILL, 16'sh7fff);
    send_item(OP_ADD, 16'sh8000);
    send_item(OP_ADD, 16'sh8000);
    drain();
    write_length(win_len_t'(MAX_WINDOW));
    send_item(OP_ADD, -16'sd1);
    send_item(OP_FILL, 16'sh8000);
    drain();
    write_length(win_len_t'(MAX_WINDOW + 1));
    send_item(OP_ADD, 16'sd0);
    drain();
    // Minus five over two must come out as minus two.
    write_length(win_len_t'(2));
    send_item(OP_ADD, -16'sd3);
    send_item(OP_ADD, -16'sd2);
    drain();
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // output register fills, the block takes one more item and then stalls its
  // input until the receiver resumes.
  task automatic test_output_backpressure();
    write_length(win_len_t'(8));
    send_item(OP_FILL, random_sample());
    hold_cycles  = 150;
    hold_request = 1'b1;
    no_gaps      = 1'b1;
    repeat (12) send_item(OP_ADD, random_sample());
    drain();
    no_gaps = 1'b0;
  endtask

  // Random phases: a fresh length, usually a fill as software would issue,
  // then a run of mostly adds with the odd fill. Some phases run with no idle
  // cycles on either side.
  task automatic test_random_windows();
    win_len_t len;
    int       count;
    opcode_t  op;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0: len = win_len_t'(0);
        1: len = win_len_t'($urandom_range(MAX_WINDOW + 1, 127));
        2: len = win_len_t'(MAX_WINDOW);
        3: len = win_len_t'(1);
        default: len = win_len_t'($urandom_range(1, MAX_WINDOW));
      endcase
      write_length(len);
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        send_item(OP_FILL, random_sample());
      end
      count = $urandom_range(20, 60);
      repeat (count) begin
        op = ($urandom_range(0, 9) == 0) ? OP_FILL : OP_ADD;
        send_item(op, random_sample());
      end
      drain();
      no_gaps = 1'b0;
    end
  endtask

  // Result side: each transfer is compared with the oldest owed average.
  always @(posedge clk) begin : check_results
    sample_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (expected_averages.size() == 0) begin
        $display("%0t ns: average %0d arrived with no item outstanding",
                 $time, out_chan.average);
        errors++;
      end else begin
        want = expected_averages.pop_front();
        if (out_chan.average !== want) begin
          $display("%0t ns: average mismatch, expected %0d, actual %0d",
                   $time, want, out_chan.average);
          errors++;
        end
      end
    end
  end

  // Receiver: before each transfer it stalls for a random number of cycles,
  // and on request it holds ready low for a long, counted stretch.
  initial begin : receiver
    int stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_chan.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  // A run that hangs is ended here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("%0t ns: run did not complete in time", $time);
    $display("status: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      window_copy[i] = '0;
    end
    write_slot = 0;
    window_sum = 0;
    length_reg = LEN_RESET;

    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.opcode         <= OP_ADD;
    in_chan.sample         <= '0;
    cfg_chan.valid         <= 1'b0;
    cfg_chan.window_length <= LEN_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The clearing pass after reset is covered by waiting on ready.
    test_reset_length();
    test_length_extremes();
    test_output_backpressure();
    test_random_windows();

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d items (%0d fills) and %0d averages over %0d length writes,",
             items_sent, fills_sent, results_seen, length_writes);
    $display("with effective windows from %0d to %0d and one long output stall.",
             shortest_window, longest_window);
    if (errors == 0 && expected_averages.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d averages never arrived",
               errors, expected_averages.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
